// ----- sv/slct_pkg.sv -----
// Package for the sustained low-confidence trip: payload and config structs,
// register indexes, reset values and default widths. No dependencies.
package slct_pkg;

   localparam int TIME_WIDTH_DEF = 16;
   localparam int CONF_WIDTH_DEF = 16;

   localparam logic [7:0] TRACKING_CODE = 8'd2;
   localparam logic [7:0] LOC_STATE_RESET = 8'd255;

   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOW_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_TRIP_TICKS    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLEAR_TICKS   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_STALE_TICKS   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GATE_ENABLE   = 3'd4;

   localparam logic [15:0] LOW_THRESHOLD_RESET = 16'd32768;
   localparam logic [15:0] TRIP_TICKS_RESET    = 16'd500;
   localparam logic [15:0] CLEAR_TICKS_RESET   = 16'd2500;
   localparam logic [15:0] STALE_TICKS_RESET   = 16'd300;

   typedef struct packed {
      logic        sample_valid;
      logic [15:0] confidence;
      logic        not_finite;
      logic        state_valid;
      logic [7:0]  loc_state_in;
   } req_type;

   typedef struct packed {
      logic        tripped;
      logic        is_low;
      logic [15:0] dwell;
      logic        engaged;
   } rsp_type;

   typedef struct packed {
      logic [15:0] low_threshold;
      logic [15:0] trip_ticks;
      logic [15:0] clear_ticks;
      logic [15:0] stale_ticks;
      logic        gate_enable;
   } cfg_type;

endpackage

// ----- sv/slct_tick.sv -----
// Per-tick state and evaluation of the trip: latched sample and state,
// sample age, dwell counter and trip flag. Depends on slct_pkg.
module slct_tick #(
   parameter int TIME_WIDTH = slct_pkg::TIME_WIDTH_DEF,
   parameter int CONF_WIDTH = slct_pkg::CONF_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  slct_pkg::req_type item,
   input  slct_pkg::cfg_type cfg,
   output slct_pkg::rsp_type result
);
   import slct_pkg::*;

   localparam int TW_EXT = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
   localparam int CW_EXT = (CONF_WIDTH > 16) ? CONF_WIDTH : 16;

   logic                  have_sample_ff, have_sample_in;
   logic [CONF_WIDTH-1:0] conf_value_ff, conf_value_in;
   logic                  conf_bad_ff, conf_bad_in;
   logic [TIME_WIDTH-1:0] sample_age_ff, sample_age_in;
   logic                  have_state_ff, have_state_in;
   logic [7:0]            loc_state_ff, loc_state_in;
   logic                  prev_low_ff, prev_low_in;
   logic                  trip_flag_ff, trip_flag_in;
   logic                  edge_seen_ff, edge_seen_in;
   logic [TIME_WIDTH-1:0] dwell_count_ff, dwell_count_in;

   logic                  engaged;
   logic                  low;
   logic                  restart;
   logic [CW_EXT-1:0]     conf_ext;
   logic [CW_EXT-1:0]     thr_ext;
   logic [TW_EXT-1:0]     age_ext;
   logic [TW_EXT-1:0]     dwell_ext;
   logic [TIME_WIDTH-1:0] dwell_step;

   always_comb begin
      conf_ext = CW_EXT'(item.confidence);
      thr_ext  = CW_EXT'(cfg.low_threshold);

      if (item.sample_valid) begin
         have_sample_in = 1'b1;
         conf_value_in  = conf_ext[CONF_WIDTH-1:0];
         conf_bad_in    = item.not_finite;
         sample_age_in  = '0;
      end else begin
         have_sample_in = have_sample_ff;
         conf_value_in  = conf_value_ff;
         conf_bad_in    = conf_bad_ff;
         sample_age_in  = (sample_age_ff == '1) ? sample_age_ff
                                                : sample_age_ff + 1'b1;
      end

      if (item.state_valid) begin
         have_state_in = 1'b1;
         loc_state_in  = item.loc_state_in;
      end else begin
         have_state_in = have_state_ff;
         loc_state_in  = loc_state_ff;
      end

      engaged = !(cfg.gate_enable && !(have_state_in && loc_state_in == TRACKING_CODE));

      age_ext = TW_EXT'(sample_age_in);
      low = !have_sample_in
            || (cfg.stale_ticks != 16'd0 && age_ext > TW_EXT'(cfg.stale_ticks))
            || conf_bad_in
            || (conf_value_in < thr_ext[CONF_WIDTH-1:0]);
      restart    = (low != prev_low_ff) || !edge_seen_ff;
      dwell_step = (dwell_count_ff == '1) ? dwell_count_ff : dwell_count_ff + 1'b1;

      if (!engaged) begin
         prev_low_in    = prev_low_ff;
         edge_seen_in   = 1'b0;
         dwell_count_in = '0;
         trip_flag_in   = 1'b0;
      end else begin
         prev_low_in    = low;
         edge_seen_in   = 1'b1;
         dwell_count_in = restart ? '0 : dwell_step;
         if (low) begin
            trip_flag_in = trip_flag_ff
                           || (TW_EXT'(dwell_count_in) >= TW_EXT'(cfg.trip_ticks));
         end else begin
            trip_flag_in = trip_flag_ff
                           && !(TW_EXT'(dwell_count_in) >= TW_EXT'(cfg.clear_ticks));
         end
      end

      dwell_ext      = TW_EXT'(dwell_count_in);
      result.tripped = trip_flag_in;
      result.is_low  = prev_low_in;
      result.dwell   = (dwell_ext > TW_EXT'(16'hFFFF)) ? 16'hFFFF : dwell_ext[15:0];
      result.engaged = engaged;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_sample_ff <= 1'b0;
         conf_value_ff  <= '0;
         conf_bad_ff    <= 1'b0;
         sample_age_ff  <= '0;
         have_state_ff  <= 1'b0;
         loc_state_ff   <= LOC_STATE_RESET;
         prev_low_ff    <= 1'b0;
         trip_flag_ff   <= 1'b0;
         edge_seen_ff   <= 1'b0;
         dwell_count_ff <= '0;
      end else if (fire) begin
         have_sample_ff <= have_sample_in;
         conf_value_ff  <= conf_value_in;
         conf_bad_ff    <= conf_bad_in;
         sample_age_ff  <= sample_age_in;
         have_state_ff  <= have_state_in;
         loc_state_ff   <= loc_state_in;
         prev_low_ff    <= prev_low_in;
         trip_flag_ff   <= trip_flag_in;
         edge_seen_ff   <= edge_seen_in;
         dwell_count_ff <= dwell_count_in;
      end
   end

endmodule

// ----- sv/sustained_low_confidence_trip.sv -----
// Sustained low-confidence trip: a request is held in the input register, then its result
// in the result register; throughput one tick per cycle while the response is not stalled,
// set by the single-pass tick evaluation between the two registers.
// Synchronous active-high reset clears the valid flags and tick state (not the data
// registers) and restores register defaults; the block takes a request in the first
// cycle after reset. Depends on slct_pkg and slct_tick.
module sustained_low_confidence_trip #(
   parameter int TIME_WIDTH = slct_pkg::TIME_WIDTH_DEF,
   parameter int CONF_WIDTH = slct_pkg::CONF_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  slct_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output slct_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [slct_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [15:0]                            csr_data
);
   import slct_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   cfg_type cfg_ff, cfg_in;
   rsp_type tick_result;
   logic    out_adv;
   logic    fire;
   logic    load;

   assign out_adv   = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_adv;
   assign req_stall = in_valid_ff && !fire;
   assign load      = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      in_valid_in  = (in_valid_ff && !fire) || load;
      rsp_valid_in = fire || (rsp_valid_ff && rsp_stall);
      cfg_in       = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_LOW_THRESHOLD: cfg_in.low_threshold = csr_data;
            REG_TRIP_TICKS:    cfg_in.trip_ticks    = csr_data;
            REG_CLEAR_TICKS:   cfg_in.clear_ticks   = csr_data;
            REG_STALE_TICKS:   cfg_in.stale_ticks   = csr_data;
            REG_GATE_ENABLE:   cfg_in.gate_enable   = csr_data[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   slct_tick #(
      .TIME_WIDTH(TIME_WIDTH),
      .CONF_WIDTH(CONF_WIDTH)
   ) u_tick (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_data_ff),
      .cfg    (cfg_ff),
      .result (tick_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
         cfg_ff.low_threshold <= LOW_THRESHOLD_RESET;
         cfg_ff.trip_ticks    <= TRIP_TICKS_RESET;
         cfg_ff.clear_ticks   <= CLEAR_TICKS_RESET;
         cfg_ff.stale_ticks   <= STALE_TICKS_RESET;
         cfg_ff.gate_enable   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         rsp_data_ff <= tick_result;
      end
   end

`ifndef SYNTH
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("request stalled with input register empty");

   a_held_item_stays: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> in_valid_ff && $stable(in_data_ff))
      else $error("held input item lost or changed");

   a_trip_needs_engage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.tripped || rsp_data.engaged))
      else $error("trip reported while disengaged");

   a_idle_dwell_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.engaged) |-> (rsp_data.dwell == 16'd0))
      else $error("dwell not cleared while disengaged");
`endif

endmodule
